// ===== sv/substring_first_index_search_assert.svh =====
// Assertion macros for the substring first-index search block.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef SUBSTRING_FIRST_INDEX_SEARCH_ASSERT_SVH
`define SUBSTRING_FIRST_INDEX_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SFIS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SFIS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sfis_pkg.sv =====
// Shared constants, types and helpers for the substring first-index search.
// No dependencies.
`timescale 1ns / 1ps

package sfis_pkg;

  localparam int PAT_MAX    = 16;
  localparam int IDX_W      = 16;
  localparam int CHAR_W     = 8;
  localparam int START_W    = 16;
  localparam int OUT_IDX_W  = 16;
  localparam int CFG_W      = 64;
  localparam int CFG_LEN_W  = 5;
  localparam int CFG_ADDR_W = 2;
  localparam int LEN_W      = $clog2(PAT_MAX + 1);
  localparam int PAT_BYTES  = (2 * CFG_W) / CHAR_W;
  localparam int CMP_W      = ((IDX_W > START_W) ? IDX_W : START_W) + 1;
  localparam int IN_TDATA_W = ((CHAR_W + START_W + 7) / 8) * 8;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_HIGH = 2'd1,
    REG_PAT_LEN  = 2'd2
  } cfg_reg_t;

  typedef logic [2*CFG_W-1:0] pat_t;

  typedef struct packed {
    logic               valid;
    logic               first;
    logic               last;
    logic [START_W-1:0] start;
  } step_t;

  typedef struct packed {
    logic                 found;
    logic [OUT_IDX_W-1:0] index;
  } result_t;

  function automatic logic [CHAR_W-1:0] pat_byte(input pat_t p, input int k);
    logic [CHAR_W-1:0] b;
    b = '0;
    if (k < PAT_BYTES) begin
      b = p[k*CHAR_W +: CHAR_W];
    end
    return b;
  endfunction

endpackage

// ===== sv/sfis_window.sv =====
// Recent-byte window and parallel pattern compare for the search block.
// Depends on sfis_pkg.
`timescale 1ns / 1ps

module sfis_window (
  input  logic                         clk,
  input  logic                         shift,
  input  logic [sfis_pkg::CHAR_W-1:0]  char_in,
  input  sfis_pkg::pat_t               pat,
  input  logic [sfis_pkg::LEN_W-1:0]   len,
  output logic                         hit
);

  logic [sfis_pkg::CHAR_W-1:0] win_r   [sfis_pkg::PAT_MAX];
  logic [sfis_pkg::CHAR_W-1:0] win_nxt [sfis_pkg::PAT_MAX];

  // Newest byte at slot 0.
  always_comb begin
    win_nxt[0] = char_in;
    for (int i = 1; i < sfis_pkg::PAT_MAX; i++) begin
      win_nxt[i] = win_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      win_r <= win_nxt;
    end
  end

  // Pattern byte k sits at slot len-1-k once the pattern ends on this byte.
  always_comb begin
    logic ok;
    hit = 1'b0;
    for (int l = 1; l <= sfis_pkg::PAT_MAX; l++) begin
      ok = 1'b1;
      for (int k = 0; k < sfis_pkg::PAT_MAX; k++) begin
        if (k < l) begin
          if (win_nxt[l-1-k] != sfis_pkg::pat_byte(pat, k)) begin
            ok = 1'b0;
          end
        end
      end
      if (len == sfis_pkg::LEN_W'(l)) begin
        hit = ok;
      end
    end
  end

endmodule

// ===== sv/sfis_track.sv =====
// Per-text position, start limit and first-match tracking; forms the result.
// Depends on sfis_pkg.
`timescale 1ns / 1ps

module sfis_track (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sfis_pkg::step_t             step,
  input  logic [sfis_pkg::LEN_W-1:0]  len,
  input  logic                        hit,
  output sfis_pkg::result_t           result
);

  localparam logic [sfis_pkg::IDX_W-1:0] IDX_MAX = '1;

  logic [sfis_pkg::IDX_W-1:0]   pos_r, pos_nxt;
  logic [sfis_pkg::START_W-1:0] start_r, start_nxt;
  logic                         seen_r, seen_nxt;
  logic [sfis_pkg::IDX_W-1:0]   fmi_r, fmi_nxt;

  logic [sfis_pkg::IDX_W-1:0]   eff_pos, eff_fmi, count, new_fmi;
  logic [sfis_pkg::START_W-1:0] eff_start;
  logic                         eff_seen, can, new_seen, empty_ok;
  logic [sfis_pkg::CMP_W-1:0]   pos1, len_x, cand, start_x, count_x, max_x;

  always_comb begin
    eff_pos   = step.first ? '0 : pos_r;
    eff_start = step.first ? step.start : start_r;
    eff_seen  = step.first ? 1'b0 : seen_r;
    eff_fmi   = step.first ? '0 : fmi_r;

    count   = (eff_pos == IDX_MAX) ? IDX_MAX : eff_pos + sfis_pkg::IDX_W'(1);
    pos1    = sfis_pkg::CMP_W'(eff_pos) + sfis_pkg::CMP_W'(1);
    len_x   = sfis_pkg::CMP_W'(len);
    cand    = pos1 - len_x;
    start_x = sfis_pkg::CMP_W'(eff_start);
    count_x = sfis_pkg::CMP_W'(count);
    max_x   = sfis_pkg::CMP_W'(IDX_MAX);

    can      = (len != '0) && !eff_seen && (pos1 >= len_x) && (cand >= start_x);
    new_seen = eff_seen | (can & hit);
    new_fmi  = (can & hit) ? sfis_pkg::IDX_W'(cand) : eff_fmi;

    empty_ok = (start_x <= count_x);
    if (len == '0) begin
      result.found = empty_ok;
      if (!empty_ok) begin
        result.index = '0;
      end else if (start_x > max_x) begin
        result.index = sfis_pkg::OUT_IDX_W'(IDX_MAX);
      end else begin
        result.index = sfis_pkg::OUT_IDX_W'(eff_start);
      end
    end else begin
      result.found = new_seen;
      result.index = new_seen ? sfis_pkg::OUT_IDX_W'(new_fmi) : '0;
    end

    pos_nxt   = step.last ? '0 : count;
    start_nxt = step.last ? '0 : eff_start;
    seen_nxt  = step.last ? 1'b0 : new_seen;
    fmi_nxt   = step.last ? '0 : new_fmi;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      start_r <= '0;
      seen_r  <= 1'b0;
      fmi_r   <= '0;
    end else if (step.valid) begin
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      seen_r  <= seen_nxt;
      fmi_r   <= fmi_nxt;
    end
  end

endmodule

// ===== sv/substring_first_index_search.sv =====
// Top level of the substring first-index search: ports, config registers,
// input and result registers. Depends on sfis_pkg, sfis_window, sfis_track.
//
//  Channel | Dir | Handshake            | Payload
//  in_     | in  | in_tvalid/in_tready  | tdata {start_offset, text_char}, tuser first, tlast last
//  out_    | out | out_tvalid/out_tready| tdata match_index, tuser found
//  cfg_    | in  | cfg_we               | cfg_addr register index, cfg_wdata value
//
// One byte per cycle sustained unless a last byte waits on a stalled result; a request waits
// in the input register, and the last byte of a text loads its result into the result register.
// The byte compare and index checks sit between the input and result registers.
// Synchronous active-low reset clears control, config and tracking state.
// A stalled result holds only last-byte requests; other bytes keep flowing.
`timescale 1ns / 1ps

module substring_first_index_search (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sfis_pkg::IN_TDATA_W-1:0]   in_tdata,   // text_char, start_offset
  input  logic                              in_tuser,   // first_of_text
  input  logic                              in_tlast,   // last_of_text
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sfis_pkg::OUT_IDX_W-1:0]    out_tdata,  // match_index
  output logic                              out_tuser,  // found
  input  logic                              cfg_we,
  input  logic [sfis_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [sfis_pkg::CFG_W-1:0]        cfg_wdata
);

  logic [sfis_pkg::CFG_W-1:0]     pat_lo_r, pat_hi_r;
  logic [sfis_pkg::CFG_LEN_W-1:0] pat_len_r;
  logic [sfis_pkg::LEN_W-1:0]     len;

  logic                           s1_valid_r;
  logic [sfis_pkg::CHAR_W-1:0]    s1_char_r;
  logic [sfis_pkg::START_W-1:0]   s1_start_r;
  logic                           s1_first_r, s1_last_r;
  logic                           advance, in_fire, hit;

  logic                           out_valid_r, out_valid_nxt;
  sfis_pkg::result_t              out_res_r, result;
  sfis_pkg::step_t                step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
      pat_len_r <= '0;
    end else if (cfg_we) begin
      unique case (sfis_pkg::cfg_reg_t'(cfg_addr))
        sfis_pkg::REG_PAT_LOW:  pat_lo_r  <= cfg_wdata;
        sfis_pkg::REG_PAT_HIGH: pat_hi_r  <= cfg_wdata;
        sfis_pkg::REG_PAT_LEN:  pat_len_r <= cfg_wdata[sfis_pkg::CFG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign len = (int'(pat_len_r) > sfis_pkg::PAT_MAX) ? sfis_pkg::LEN_W'(sfis_pkg::PAT_MAX)
                                                      : sfis_pkg::LEN_W'(pat_len_r);

  // Non-last bytes never need the result slot.
  assign advance   = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r  <= in_tdata[sfis_pkg::CHAR_W-1:0];
      s1_start_r <= in_tdata[sfis_pkg::CHAR_W +: sfis_pkg::START_W];
      s1_first_r <= in_tuser;
      s1_last_r  <= in_tlast;
    end
  end

  assign step.valid = advance;
  assign step.first = s1_first_r;
  assign step.last  = s1_last_r;
  assign step.start = s1_start_r;

  sfis_window u_window (
    .clk     (clk),
    .shift   (advance),
    .char_in (s1_char_r),
    .pat     ({pat_hi_r, pat_lo_r}),
    .len     (len),
    .hit     (hit)
  );

  sfis_track u_track (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .len    (len),
    .hit    (hit),
    .result (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last_r) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.index;
  assign out_tuser  = out_res_r.found;

`include "substring_first_index_search_assert.svh"

  `SFIS_ASSERT_NXT(a_last_gives_result, advance && s1_last_r, out_valid_r, "last byte gave no result")
  `SFIS_ASSERT_IMP(a_miss_index_zero, out_valid_r && !out_tuser, out_tdata == '0, "miss with nonzero index")
  `SFIS_ASSERT_NXT(a_stall_holds_s1, s1_valid_r && !advance, s1_valid_r && $stable(s1_char_r), "stalled request lost")

endmodule
